// ===== design/bfknn_pkg.sv =====
// ----------------------------------------------------------------------------
// bfknn_pkg
// Shared types and constants for the brute-force k-nearest-neighbor block.
// ----------------------------------------------------------------------------
package bfknn_pkg;

  // Fixed field widths
  localparam int ELEM_BITS  = 16;
  localparam int PNUM_W     = 20;
  localparam int PTS_W      = PNUM_W + 1;
  localparam int MAX_POINTS = 1 << PNUM_W;
  localparam int DIM_REG_W  = 8;
  localparam int K_REG_W    = 5;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM_IN_USE       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBORS_WANTED = 4'd1;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_BASE   = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN,
    S_REPORT
  } state_t;

  // Travels with a base element down the distance pipe
  typedef struct packed {
    logic              last;  // final element of its vector
    logic              keep;  // point fits under capacity
    logic [PNUM_W-1:0] pnum;
  } elem_tag_t;

  // Commands to every cell of the list
  typedef struct packed {
    logic ins;    // insert candidate this cycle
    logic shift;  // move entries one place toward the head
    logic clear;  // empty the list
  } chain_ctl_t;

endpackage

// ===== design/bfknn_dist.sv =====
// ----------------------------------------------------------------------------
// bfknn_dist
// Query store and squared-distance pipe: read, abs diff, square, accumulate.
// ----------------------------------------------------------------------------
module bfknn_dist #(
  parameter int MAX_DIM = 128,
  parameter int DIM_IW  = 7,
  parameter int ACC_W   = 39
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_we,
  input  logic [DIM_IW-1:0]                q_waddr,
  input  logic [bfknn_pkg::ELEM_BITS-1:0]  q_wdata,
  input  logic                             b_valid,
  input  logic [DIM_IW-1:0]                b_addr,
  input  logic [bfknn_pkg::ELEM_BITS-1:0]  b_elem,
  input  bfknn_pkg::elem_tag_t             b_tag,
  input  logic                             acc_clear,
  output logic                             ins_valid,
  output logic [ACC_W-1:0]                 ins_dist,
  output logic [bfknn_pkg::PNUM_W-1:0]     ins_pnum,
  output logic                             pending
);

  localparam int EW = bfknn_pkg::ELEM_BITS;

  logic [EW-1:0]        qmem [MAX_DIM];
  logic [MAX_DIM-1:0]   qvalid;

  // stage A: query read
  logic                 va;
  logic [EW-1:0]        q_a;
  logic [EW-1:0]        e_a;
  bfknn_pkg::elem_tag_t tag_a;
  // stage B: absolute difference
  logic                 vb;
  logic [EW-1:0]        absd;
  bfknn_pkg::elem_tag_t tag_b;
  // stage C: square
  logic                 vc;
  logic [2*EW-1:0]      prod;
  bfknn_pkg::elem_tag_t tag_c;
  // stage D: accumulate
  logic [ACC_W-1:0]     acc;

  logic signed [EW:0]   diff;
  logic [ACC_W-1:0]     sum;

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid <= '0;
    end else if (q_we) begin
      qvalid[q_waddr] <= 1'b1;
    end
  end

  // unwritten query entries read as zero
  always_ff @(posedge clk) begin
    q_a   <= qvalid[b_addr] ? qmem[b_addr] : '0;
    e_a   <= b_elem;
    tag_a <= b_tag;
  end

  assign diff = $signed({q_a[EW-1], q_a}) - $signed({e_a[EW-1], e_a});
  assign sum  = acc + ACC_W'(prod);

  always_ff @(posedge clk) begin
    absd  <= diff[EW] ? EW'(-diff) : diff[EW-1:0];
    tag_b <= tag_a;
    prod  <= absd * absd;
    tag_c <= tag_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      ins_valid <= 1'b0;
      acc       <= '0;
    end else begin
      va        <= b_valid;
      vb        <= va;
      vc        <= vb;
      ins_valid <= vc && tag_c.last && tag_c.keep;
      if (acc_clear) begin
        acc <= '0;
      end else if (vc) begin
        acc <= tag_c.last ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    ins_dist <= sum;
    ins_pnum <= tag_c.pnum;
  end

  assign pending = va || vb || vc || ins_valid;

endmodule

// ===== design/bfknn_cell.sv =====
// ----------------------------------------------------------------------------
// bfknn_cell
// One place of the sorted best-K list; inserts in parallel, shifts for readout.
// ----------------------------------------------------------------------------
module bfknn_cell #(
  parameter int ACC_W = 39
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bfknn_pkg::chain_ctl_t        ctl,
  input  logic [ACC_W-1:0]             new_dist,
  input  logic [bfknn_pkg::PNUM_W-1:0] new_pnum,
  input  logic                         prev_less,
  input  logic [ACC_W-1:0]             prev_dist,
  input  logic [bfknn_pkg::PNUM_W-1:0] prev_pnum,
  input  logic [ACC_W-1:0]             next_dist,
  input  logic [bfknn_pkg::PNUM_W-1:0] next_pnum,
  output logic [ACC_W-1:0]             cur_dist,
  output logic [bfknn_pkg::PNUM_W-1:0] cur_pnum,
  output logic                         less
);

  // strict compare: an equal distance stays behind the older point
  assign less = new_dist < cur_dist;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      cur_dist <= '1;
      cur_pnum <= '0;
    end else if (ctl.shift) begin
      cur_dist <= next_dist;
      cur_pnum <= next_pnum;
    end else if (ctl.ins && less) begin
      cur_dist <= prev_less ? prev_dist : new_dist;
      cur_pnum <= prev_less ? prev_pnum : new_pnum;
    end
  end

endmodule

// ===== design/brute_force_knn_topk_top.sv =====
// ----------------------------------------------------------------------------
// brute_force_knn_topk_top
// Exact k-nearest-neighbor search by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Query and base elements are taken one per cycle with busy low: a query
// element goes straight into the query store, a base element enters a
// four-stage distance pipe (query read, abs diff, square, accumulate). The
// last element of a vector hands its distance to a row of MAX_K list cells,
// which all compare against it in the same cycle and shift to make room, so
// one point can be inserted every cycle. A finish raises busy: the block
// waits for the distance pipe to drain, then presents
// min(neighbors_wanted, points seen) results on consecutive cycles, nearest
// first, each marked by result_valid for exactly one cycle; there is no
// backpressure on results, so the receiver must take each transfer as it
// comes. A finish with no base points gives a single transfer with status 1.
// The list empties itself on the final result and busy drops the cycle after.
// Query store: 1 write port (query elements), 1 registered read port (base).
// ----------------------------------------------------------------------------
module brute_force_knn_topk_top #(
  parameter int MAX_DIM = 128,
  parameter int MAX_K   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          op,
  input  logic [bfknn_pkg::ELEM_BITS-1:0]     element_value,
  input  logic                                cfg_write,
  input  logic [bfknn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfknn_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                result_valid,
  output logic [bfknn_pkg::PNUM_W-1:0]        point_number,
  output logic [2*bfknn_pkg::ELEM_BITS+$clog2(MAX_DIM)-1:0] squared_distance,
  output logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0]      rank,
  output logic                                last_result,
  output logic                                status
);

  localparam int DIM_IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_CW = $clog2(MAX_DIM + 1);
  localparam int ACC_W  = 2 * bfknn_pkg::ELEM_BITS + $clog2(MAX_DIM);
  localparam int RANK_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KC_W   = $clog2(MAX_K + 1);
  localparam int PNW    = bfknn_pkg::PNUM_W;
  localparam int PTW    = bfknn_pkg::PTS_W;

  // configuration
  logic [bfknn_pkg::DIM_REG_W-1:0] dim_reg;
  logic [bfknn_pkg::K_REG_W-1:0]   k_reg;
  logic [DIM_CW-1:0]               eff_dim;
  logic [KC_W-1:0]                 eff_k;

  // stream bookkeeping
  logic                 accept;
  logic [DIM_IW-1:0]    qfill;
  logic [DIM_IW-1:0]    q_idx;
  logic [DIM_IW-1:0]    q_idx_next;
  logic [DIM_IW-1:0]    bidx;
  logic                 b_end;
  logic                 b_keep;
  logic [PTW-1:0]       pts;
  logic [KC_W-1:0]      fill_k;
  logic [KC_W-1:0]      report_cnt;

  // report control
  bfknn_pkg::state_t    state;
  bfknn_pkg::state_t    state_next;
  logic [RANK_W-1:0]    rank_cnt;
  logic                 empty;
  logic                 acc_clear;
  bfknn_pkg::chain_ctl_t chain_ctl;

  // distance pipe
  logic                 q_we;
  logic                 b_valid;
  bfknn_pkg::elem_tag_t b_tag;
  logic                 ins_valid;
  logic [ACC_W-1:0]     ins_dist;
  logic [PNW-1:0]       ins_pnum;
  logic                 pending;

  // list cells
  logic [ACC_W-1:0]     cell_dist [MAX_K];
  logic [PNW-1:0]       cell_pnum [MAX_K];
  logic                 cell_less [MAX_K];

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg <= 8'd128;
      k_reg   <= 5'd16;
    end else if (cfg_write) begin
      if (cfg_index == bfknn_pkg::REG_DIM_IN_USE) begin
        dim_reg <= cfg_data[bfknn_pkg::DIM_REG_W-1:0];
      end else if (cfg_index == bfknn_pkg::REG_NEIGHBORS_WANTED) begin
        k_reg <= cfg_data[bfknn_pkg::K_REG_W-1:0];
      end
    end
  end

  // zero counts as one, oversize clamps to the built capacity
  always_comb begin
    if (dim_reg == '0) begin
      eff_dim = DIM_CW'(1);
    end else if (32'(dim_reg) > 32'(MAX_DIM)) begin
      eff_dim = DIM_CW'(MAX_DIM);
    end else begin
      eff_dim = DIM_CW'(dim_reg);
    end
    if (k_reg == '0) begin
      eff_k = KC_W'(1);
    end else if (32'(k_reg) > 32'(MAX_K)) begin
      eff_k = KC_W'(MAX_K);
    end else begin
      eff_k = KC_W'(k_reg);
    end
  end

  // ---------------- input side ----------------
  assign accept = start && !busy;

  always_comb begin
    // a shrunk dimension wraps the query fill pointer
    q_idx      = (32'(qfill) >= 32'(eff_dim)) ? '0 : qfill;
    q_idx_next = (32'(q_idx) + 32'd1 >= 32'(eff_dim)) ? '0 : DIM_IW'(32'(q_idx) + 32'd1);
    b_end      = 32'(bidx) + 32'd1 >= 32'(eff_dim);
    b_keep     = 32'(pts) < 32'(bfknn_pkg::MAX_POINTS);
    fill_k     = (32'(pts) >= 32'(MAX_K)) ? KC_W'(MAX_K) : KC_W'(pts);
  end

  assign q_we    = accept && (op == bfknn_pkg::OP_QUERY);
  assign b_valid = accept && (op == bfknn_pkg::OP_BASE);
  assign b_tag   = '{last: b_end, keep: b_keep, pnum: pts[PNW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      qfill      <= '0;
      bidx       <= '0;
      pts        <= '0;
      empty      <= 1'b0;
      report_cnt <= '0;
      rank_cnt   <= '0;
    end else begin
      if (accept) begin
        unique case (op)
          bfknn_pkg::OP_QUERY: begin
            qfill <= q_idx_next;
          end
          bfknn_pkg::OP_BASE: begin
            if (b_end) begin
              bidx <= '0;
              if (b_keep) begin
                pts <= pts + PTW'(1);
              end
            end else begin
              bidx <= bidx + DIM_IW'(1);
            end
          end
          bfknn_pkg::OP_FINISH: begin
            // partial base vector is dropped here
            empty      <= (pts == '0);
            report_cnt <= (eff_k < fill_k) ? eff_k : fill_k;
            rank_cnt   <= '0;
            pts        <= '0;
            bidx       <= '0;
          end
          default: begin
          end
        endcase
      end
      if (chain_ctl.shift) begin
        rank_cnt <= rank_cnt + RANK_W'(1);
      end
    end
  end

  // ---------------- report sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfknn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign last_result = empty || (KC_W'(rank_cnt) + KC_W'(1) == report_cnt);

  always_comb begin
    state_next = state;
    unique case (state)
      bfknn_pkg::S_IDLE: begin
        if (accept && op == bfknn_pkg::OP_FINISH) begin
          state_next = bfknn_pkg::S_DRAIN;
        end
      end
      bfknn_pkg::S_DRAIN: begin
        if (!pending) begin
          state_next = bfknn_pkg::S_REPORT;
        end
      end
      bfknn_pkg::S_REPORT: begin
        if (last_result) begin
          state_next = bfknn_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    busy            = 1'b1;
    result_valid    = 1'b0;
    acc_clear       = 1'b0;
    chain_ctl.ins   = ins_valid;
    chain_ctl.shift = 1'b0;
    chain_ctl.clear = 1'b0;
    unique case (state)
      bfknn_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      bfknn_pkg::S_DRAIN: begin
        acc_clear = !pending;
      end
      bfknn_pkg::S_REPORT: begin
        result_valid    = 1'b1;
        chain_ctl.shift = !last_result;
        chain_ctl.clear = last_result;
      end
    endcase
  end

  // head cell is the next result; the error result carries zeros
  assign point_number     = empty ? '0 : cell_pnum[0];
  assign squared_distance = empty ? '0 : cell_dist[0];
  assign rank             = rank_cnt;
  assign status           = empty;

  // ---------------- datapath ----------------
  bfknn_dist #(
    .MAX_DIM (MAX_DIM),
    .DIM_IW  (DIM_IW),
    .ACC_W   (ACC_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .q_we      (q_we),
    .q_waddr   (q_idx),
    .q_wdata   (element_value),
    .b_valid   (b_valid),
    .b_addr    (bidx),
    .b_elem    (element_value),
    .b_tag     (b_tag),
    .acc_clear (acc_clear),
    .ins_valid (ins_valid),
    .ins_dist  (ins_dist),
    .ins_pnum  (ins_pnum),
    .pending   (pending)
  );

  // Row of list cells, cell 0 holds the nearest point. Unused cells hold
  // all ones, which no real distance reaches.
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic             p_less;
    logic [ACC_W-1:0] p_dist;
    logic [PNW-1:0]   p_pnum;
    logic [ACC_W-1:0] n_dist;
    logic [PNW-1:0]   n_pnum;

    if (i == 0) begin : g_head
      assign p_less = 1'b0;
      assign p_dist = '1;
      assign p_pnum = '0;
    end else begin : g_mid
      assign p_less = cell_less[i-1];
      assign p_dist = cell_dist[i-1];
      assign p_pnum = cell_pnum[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign n_dist = '1;
      assign n_pnum = '0;
    end else begin : g_body
      assign n_dist = cell_dist[i+1];
      assign n_pnum = cell_pnum[i+1];
    end

    bfknn_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (chain_ctl),
      .new_dist  (ins_dist),
      .new_pnum  (ins_pnum),
      .prev_less (p_less),
      .prev_dist (p_dist),
      .prev_pnum (p_pnum),
      .next_dist (n_dist),
      .next_pnum (n_pnum),
      .cur_dist  (cell_dist[i]),
      .cur_pnum  (cell_pnum[i]),
      .less      (cell_less[i])
    );
  end

  // ---------------- assertions ----------------
  // no insert may still be in flight while results go out
  a_drained: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !pending)
    else $error("distance pipe busy during report");

  // a report runs on consecutive cycles until its last transfer
  a_contig: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |=> result_valid && (rank == $past(rank) + RANK_W'(1)))
    else $error("report broken or rank skipped");

  // the no-point error is a single transfer at rank zero
  a_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> last_result && (rank == '0))
    else $error("error result malformed");

  // a finish always holds off further input
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (op == bfknn_pkg::OP_FINISH) |=> busy)
    else $error("finish did not raise busy");

  // the list head never holds a farther point than its neighbor
  if (MAX_K > 1) begin : g_sorted_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      cell_dist[0] <= cell_dist[1])
      else $error("list head out of order");
  end

endmodule
